// ===== hw/rtl/windowed_read_histogram_core_assert.svh =====
// Assertion macros for the windowed read histogram core.
`ifndef WINDOWED_READ_HISTOGRAM_CORE_ASSERT_SVH
`define WINDOWED_READ_HISTOGRAM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define WRH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("windowed read histogram check failed");
`define WRH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("windowed read histogram check failed");
`else
`define WRH_ASSERT_NOW(label, ante, cons)
`define WRH_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/wrh_pkg.sv =====
// Shared constants, types and helpers of the windowed read histogram core.
package wrh_pkg;

  localparam int NUM_REFS    = 8;
  localparam int NUM_WINDOWS = 1024;
  localparam int COUNT_WIDTH = 32;

  localparam int STORE_DEPTH = NUM_REFS * NUM_WINDOWS;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int WIN_W       = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;

  localparam int CMD_W      = 1;
  localparam int REF_W      = 3;
  localparam int POS_W      = 28;
  localparam int QUAL_W     = 8;
  localparam int WIDX_W     = 10;
  localparam int WSIZE_W    = 24;
  localparam int COORD_W    = 34;
  localparam int READ_CNT_W = 32;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [CMD_W-1:0] CMD_RECORD = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ   = 1'b1;

  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_MIN_QUALITY = 1'b1;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic logic [READ_CNT_W-1:0] clip_count(input count_t c);
    logic [63:0] w;
    w = 64'(c);
    if (w > 64'(32'hFFFF_FFFF)) begin
      return '1;
    end
    return w[READ_CNT_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/wrh_divider.sv =====
// Radix-2 restoring divider: position over window size, one quotient bit per cycle.
module wrh_divider (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wrh_pkg::POS_W-1:0]     dividend,
  input  logic [wrh_pkg::WSIZE_W-1:0]   divisor,
  output logic [wrh_pkg::POS_W-1:0]     quotient,
  output wrh_pkg::div_status_t          status
);
  import wrh_pkg::*;

  localparam int CNT_W = $clog2(POS_W + 1);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(POS_W - 1);

  logic [POS_W-1:0]   quo_r;
  logic [WSIZE_W-1:0] rem_r;
  logic [WSIZE_W-1:0] dvs_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               busy_r;
  logic               done_r;

  logic [WSIZE_W:0] shifted;
  logic [WSIZE_W:0] diff;
  logic             ge;

  always_comb begin
    shifted = {rem_r, quo_r[POS_W-1]};
    diff    = shifted - {1'b0, dvs_r};
    ge      = (shifted >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[WSIZE_W-1:0] : shifted[WSIZE_W-1:0];
      quo_r <= {quo_r[POS_W-2:0], ge};
    end
  end

  assign quotient    = quo_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// ===== hw/rtl/windowed_read_histogram_core.sv =====
// Windowed read histogram: per-reference, per-window saturating read counts.
//
// Input channel (in_valid / in_stall): one word per command. A record word
// (in_cmd = 0) bumps the count of bin position / window length of its reference
// unless it is excluded or below min_quality; a read word (in_cmd = 1) returns
// the coordinates and count of one bin. Every word gives exactly one result
// word on the output channel (out_valid / out_stall).
// A counted record word passes through the 28-step bit-serial divider, then
// one count-memory read and one write back; a record past the last window
// skips the memory, dropped records and reads outside the store go straight
// to the result, and other reads take one count-memory read. One word is in
// work at a time; the next word is taken the cycle after the result is loaded,
// so in_stall stays high while a word is in work or its result waits.
// Reset clears the 8192-entry count memory one entry a cycle, so in_stall
// stays high until the last entry is cleared; configuration writes over the
// APB port are taken throughout. A stalled result holds in the output
// register, and at most one more word completes behind it before in_stall
// stays high.
`include "windowed_read_histogram_core_assert.svh"
module windowed_read_histogram_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [wrh_pkg::CMD_W-1:0]        in_cmd,
  input  logic [wrh_pkg::REF_W-1:0]        in_ref_index,
  input  logic [wrh_pkg::POS_W-1:0]        in_position,
  input  logic [wrh_pkg::QUAL_W-1:0]       in_map_quality,
  input  logic                             in_excluded,
  input  logic [wrh_pkg::WIDX_W-1:0]       in_window_index,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_counted,
  output logic                             out_out_of_range,
  output logic [wrh_pkg::COORD_W-1:0]      out_window_start,
  output logic [wrh_pkg::COORD_W-1:0]      out_window_end,
  output logic [wrh_pkg::READ_CNT_W-1:0]   out_read_count,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [wrh_pkg::PADDR_W-1:0]      paddr,
  input  logic [wrh_pkg::PDATA_W-1:0]      pwdata,
  output logic [wrh_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready
);
  import wrh_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_LOOKUP = 3'd3;
  localparam logic [2:0] S_UPDATE = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_DEPTH - 1);

  logic [WSIZE_W-1:0] wsize_r;
  logic [QUAL_W-1:0]  minq_r;
  logic [WSIZE_W-1:0] ws_eff;
  logic               cfg_wr;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [REF_W-1:0]   ref_r;
  logic [WIN_W-1:0]   idx_r;
  logic [COORD_W-1:0] prod_r;
  logic               oor_r;
  logic               counted_r;

  logic                  out_valid_r;
  logic                  out_counted_r;
  logic                  out_oor_r;
  logic [COORD_W-1:0]    out_start_r;
  logic [COORD_W-1:0]    out_end_r;
  logic [READ_CNT_W-1:0] out_count_r;

  count_t            count_mem [STORE_DEPTH];
  count_t            rd_data_r;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  count_t            mem_wdata;
  logic [ADDR_W-1:0] bin_addr;
  count_t            bumped;

  logic              in_acc;
  logic              drop;
  logic              ref_oor;
  logic              widx_oor;
  logic              bin_oor;
  logic              div_start;
  logic              out_load;
  logic [POS_W-1:0]  quotient;
  div_status_t       div_st;

  // configuration registers
  assign cfg_wr = psel & penable & pwrite & pready;
  assign pready = 1'b1;
  assign ws_eff = (wsize_r == '0) ? WSIZE_W'(1) : wsize_r;
  assign prdata = (paddr[2] == REG_MIN_QUALITY) ? PDATA_W'(minq_r) : PDATA_W'(wsize_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wsize_r <= WSIZE_W'(1);
      minq_r  <= '0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WINDOW_SIZE) begin
        wsize_r <= pwdata[WSIZE_W-1:0];
      end else begin
        minq_r <= pwdata[QUAL_W-1:0];
      end
    end
  end

  // item decode
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign drop     = in_excluded | (in_map_quality < minq_r);
  assign ref_oor  = (32'(in_ref_index) >= 32'(NUM_REFS));
  assign widx_oor = (32'(in_window_index) >= 32'(NUM_WINDOWS));
  assign bin_oor  = (32'(ref_r) >= 32'(NUM_REFS)) | (32'(quotient) >= 32'(NUM_WINDOWS));
  assign div_start = in_acc & (in_cmd == CMD_RECORD) & ~drop;
  assign out_load  = (state_r == S_DONE) & (~out_valid_r | ~out_stall);

  wrh_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_position),
    .divisor  (ws_eff),
    .quotient (quotient),
    .status   (div_st)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_READ) begin
            state_nxt = (ref_oor | widx_oor) ? S_DONE : S_LOOKUP;
          end else begin
            state_nxt = drop ? S_DONE : S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_st.done) state_nxt = bin_oor ? S_DONE : S_LOOKUP;
      end
      S_LOOKUP: state_nxt = S_UPDATE;
      S_UPDATE: state_nxt = S_DONE;
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r     <= in_cmd;
      ref_r     <= in_ref_index;
      idx_r     <= WIN_W'(in_window_index);
      prod_r    <= COORD_W'(ws_eff) * COORD_W'(in_window_index);
      counted_r <= 1'b0;
      oor_r     <= (in_cmd == CMD_READ) & (ref_oor | widx_oor);
    end else begin
      if (state_r == S_DIV && div_st.done) begin
        oor_r <= bin_oor;
        idx_r <= WIN_W'(quotient);
      end
      if (state_r == S_UPDATE && cmd_r == CMD_RECORD) counted_r <= 1'b1;
    end
  end

  // count memory: read, bump, write back
  assign bin_addr  = ADDR_W'(32'(ref_r) * 32'(NUM_WINDOWS) + 32'(idx_r));
  assign bumped    = (rd_data_r == COUNT_MAX) ? rd_data_r : rd_data_r + 1'b1;
  assign mem_re    = (state_r == S_LOOKUP);
  assign mem_we    = (state_r == S_CLEAR) | ((state_r == S_UPDATE) & (cmd_r == CMD_RECORD));
  assign mem_waddr = (state_r == S_CLEAR) ? clr_addr_r : bin_addr;
  assign mem_wdata = (state_r == S_CLEAR) ? '0 : bumped;

  always_ff @(posedge clk) begin
    if (mem_we) count_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data_r <= count_mem[bin_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_counted_r <= counted_r;
      out_oor_r     <= oor_r;
      if (cmd_r == CMD_READ) begin
        out_start_r <= prod_r + COORD_W'(1);
        out_end_r   <= prod_r + COORD_W'(ws_eff);
        out_count_r <= oor_r ? '0 : clip_count(rd_data_r);
      end else begin
        out_start_r <= '0;
        out_end_r   <= '0;
        out_count_r <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_counted      = out_counted_r;
  assign out_out_of_range = out_oor_r;
  assign out_window_start = out_start_r;
  assign out_window_end   = out_end_r;
  assign out_read_count   = out_count_r;

  `WRH_ASSERT_NOW(a_div_only_in_div, div_st.busy | div_st.done, state_r == S_DIV)
  `WRH_ASSERT_NOW(a_write_only_record, mem_we & (state_r != S_CLEAR), cmd_r == CMD_RECORD)
  `WRH_ASSERT_NOW(a_flags_exclusive, out_valid_r, !(out_counted_r && out_oor_r))
  `WRH_ASSERT_NOW(a_clear_complete, (state_r == S_CLEAR) && (state_nxt == S_IDLE),
                  clr_addr_r == LAST_ADDR)
  `WRH_ASSERT_NEXT(a_lookup_then_update, state_r == S_LOOKUP, state_r == S_UPDATE)

endmodule
